// ----- sv/durs_pkg.sv -----
// Shared types and constants for the dual ultrasonic ranging sequencer.
// No dependencies; imported by every module of the block.
package durs_pkg;

  // Field and register widths
  localparam int unsigned RangeW    = 16;
  localparam int unsigned PrescW    = 11;
  localparam int unsigned PrescCntW = 10;
  localparam int unsigned EdgeCntW  = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTriggerTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeoutCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWaitPrescale = 2'd2;

  // Register reset values
  localparam logic [RangeW-1:0] TriggerTicksRst = 16'd160;
  localparam logic [RangeW-1:0] TimeoutCountRst = 16'd30000;
  localparam logic [PrescW-1:0] WaitPrescaleRst = 11'd8;

  // Prescaler limit and echo 2 capture edge count
  localparam logic [PrescW-1:0]   MaxPrescale     = 11'd1024;
  localparam logic [EdgeCntW-1:0] EdgesForCapture = 2'd2;
  localparam logic [RangeW-1:0]   TimerMax        = 16'hFFFF;

  // Sequencer phases, one-hot
  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhS1Trig = 5'b00010,
    PhS1Wait = 5'b00100,
    PhS2Trig = 5'b01000,
    PhS2Wait = 5'b10000
  } phase_e;

  // Next timer state from one echo wait tick
  typedef struct packed {
    logic [RangeW-1:0]    timer;
    logic [PrescCntW-1:0] presc_cnt;
    logic                 expired;
  } wait_step_t;

endpackage

// ----- sv/durs_wait_timer.sv -----
// Prescaled echo wait timer: one tick of the timer and its timeout check.
// Depends on durs_pkg.
module durs_wait_timer (
  input  logic [durs_pkg::RangeW-1:0]    timer_i,
  input  logic [durs_pkg::PrescCntW-1:0] presc_cnt_i,
  input  logic [durs_pkg::PrescW-1:0]    wait_prescale_i,
  input  logic [durs_pkg::RangeW-1:0]    timeout_count_i,
  output durs_pkg::wait_step_t           step_o
);
  import durs_pkg::*;

  logic [PrescW-1:0] eff_presc;
  logic [PrescW-1:0] presc_next;

  // Clamp the prescale to 1..1024
  always_comb begin
    priority if (wait_prescale_i == '0) begin
      eff_presc = PrescW'(1);
    end else if (wait_prescale_i > MaxPrescale) begin
      eff_presc = MaxPrescale;
    end else begin
      eff_presc = wait_prescale_i;
    end
  end

  assign presc_next = {1'b0, presc_cnt_i} + PrescW'(1);

  // Advance the timer on prescaler wrap, saturating at full scale
  always_comb begin
    step_o.timer     = timer_i;
    step_o.presc_cnt = presc_next[PrescCntW-1:0];
    if (presc_next >= eff_presc) begin
      step_o.presc_cnt = '0;
      if (timer_i != TimerMax) begin
        step_o.timer = timer_i + RangeW'(1);
      end
    end
    step_o.expired = (step_o.timer >= timeout_count_i);
  end

endmodule

// ----- sv/dual_ultrasonic_ranging_sequencer.sv -----
// Top level of the dual ultrasonic ranging sequencer.
// Depends on durs_pkg and durs_wait_timer.
//
// One input transaction is one tick: a start request and both echo pin levels.
// Every input transaction yields exactly one result transaction carrying both
// trigger levels, busy, done, start refused and the two held ranges as they
// stand after that tick. The block takes one transaction per cycle while the
// result channel is not stalled; the sequencer update moves an accepted input
// from the input register into the result register. A start while idle presets
// both ranges to timeout_count, raises sensor 1's trigger for trigger_ticks ticks,
// then waits for a falling edge on echo one, counting the timer once every
// wait_prescale ticks; sensor 2 follows and captures on its second echo edge.
// Users must write configuration only with no transaction in flight; not enforced.
module dual_ultrasonic_ranging_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [durs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [durs_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_req_i,
  input  logic                          echo_one_i,
  input  logic                          echo_two_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          trig_one_o,
  output logic                          trig_two_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic                          start_refused_o,
  output logic [durs_pkg::RangeW-1:0]   range_one_o,
  output logic [durs_pkg::RangeW-1:0]   range_two_o
);
  import durs_pkg::*;

  // Configuration registers
  logic [RangeW-1:0] trigger_ticks_q;
  logic [RangeW-1:0] timeout_count_q;
  logic [PrescW-1:0] wait_prescale_q;

  // Input register
  logic in_vld_q;
  logic start_q, echo_one_q, echo_two_q;

  // Sequencer state
  phase_e               phase_q, phase_d;
  logic [RangeW-1:0]    timer_q, timer_d;
  logic [PrescCntW-1:0] presc_cnt_q, presc_cnt_d;
  logic [RangeW-1:0]    held_one_q, held_one_d;
  logic [RangeW-1:0]    held_two_q, held_two_d;
  logic [EdgeCntW-1:0]  edges_q, edges_d;
  logic                 last_one_q, last_two_q;

  // Result register
  logic out_vld_q;
  logic trig_one_q, trig_two_q, busy_q, done_q, refused_q;
  logic done_d, refused_d;

  logic       step;
  logic       fall_one, edge_two;
  logic [RangeW-1:0] timer_inc;
  wait_step_t wstep;

  // Move the held transaction to the result side when that side is free
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_ticks_q <= TriggerTicksRst;
      timeout_count_q <= TimeoutCountRst;
      wait_prescale_q <= WaitPrescaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgTriggerTicks: trigger_ticks_q <= cfg_data_i;
        CfgTimeoutCount: timeout_count_q <= cfg_data_i;
        CfgWaitPrescale: wait_prescale_q <= cfg_data_i[PrescW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      start_q    <= start_req_i;
      echo_one_q <= echo_one_i;
      echo_two_q <= echo_two_i;
    end
  end

  assign fall_one  = last_one_q && !echo_one_q;
  assign edge_two  = last_two_q != echo_two_q;
  assign timer_inc = (timer_q != TimerMax) ? timer_q + RangeW'(1) : timer_q;

  durs_wait_timer u_wait_timer (
    .timer_i         (timer_q),
    .presc_cnt_i     (presc_cnt_q),
    .wait_prescale_i (wait_prescale_q),
    .timeout_count_i (timeout_count_q),
    .step_o          (wstep)
  );

  // Sequencer update for one tick
  always_comb begin
    phase_d     = phase_q;
    timer_d     = timer_q;
    presc_cnt_d = presc_cnt_q;
    held_one_d  = held_one_q;
    held_two_d  = held_two_q;
    edges_d     = edges_q;
    done_d      = 1'b0;
    refused_d   = start_q && (phase_q != PhIdle);
    unique case (phase_q)
      PhS1Trig, PhS2Trig: begin
        timer_d = timer_inc;
        if (timer_inc >= trigger_ticks_q) begin
          phase_d     = (phase_q == PhS1Trig) ? PhS1Wait : PhS2Wait;
          timer_d     = '0;
          presc_cnt_d = '0;
        end
      end
      PhS1Wait: begin
        timer_d     = wstep.timer;
        presc_cnt_d = wstep.presc_cnt;
        if (fall_one) begin
          held_one_d = timer_q;
        end
        if (fall_one || wstep.expired) begin
          phase_d     = PhS2Trig;
          timer_d     = '0;
          presc_cnt_d = '0;
        end
      end
      PhS2Wait: begin
        timer_d     = wstep.timer;
        presc_cnt_d = wstep.presc_cnt;
        if (edge_two && edges_q < EdgesForCapture) begin
          edges_d = edges_q + EdgeCntW'(1);
        end
        if (edge_two && edges_d >= EdgesForCapture) begin
          held_two_d = timer_q;
        end
        if ((edge_two && edges_d >= EdgesForCapture) || wstep.expired) begin
          phase_d     = PhIdle;
          timer_d     = '0;
          presc_cnt_d = '0;
          done_d      = 1'b1;
        end
      end
      default: begin
        // idle: launch a new cycle on start
        refused_d = 1'b0;
        phase_d   = PhIdle;
        if (start_q) begin
          held_one_d  = timeout_count_q;
          held_two_d  = timeout_count_q;
          edges_d     = '0;
          phase_d     = PhS1Trig;
          timer_d     = '0;
          presc_cnt_d = '0;
        end
      end
    endcase
  end

  // Hold sequencer state, advance once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      timer_q     <= '0;
      presc_cnt_q <= '0;
      held_one_q  <= '0;
      held_two_q  <= '0;
      edges_q     <= '0;
      last_one_q  <= 1'b0;
      last_two_q  <= 1'b0;
    end else if (step) begin
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      presc_cnt_q <= presc_cnt_d;
      held_one_q  <= held_one_d;
      held_two_q  <= held_two_d;
      edges_q     <= edges_d;
      last_one_q  <= echo_one_q;
      last_two_q  <= echo_two_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      trig_one_q <= (phase_d == PhS1Trig);
      trig_two_q <= (phase_d == PhS2Trig);
      busy_q     <= (phase_d != PhIdle);
      done_q     <= done_d;
      refused_q  <= refused_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign trig_one_o      = trig_one_q;
  assign trig_two_o      = trig_two_q;
  assign busy_res_o      = busy_q;
  assign done_res_o      = done_q;
  assign start_refused_o = refused_q;
  assign range_one_o     = held_one_q;
  assign range_two_o     = held_two_q;

endmodule

// ----- sv/durs_checker.sv -----
// Port-level checks for the dual ultrasonic ranging sequencer.
// Depends on durs_pkg; bound to the top level at the end of this file.
module durs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        trig_one_o,
  input logic                        trig_two_o,
  input logic                        busy_res_o,
  input logic                        done_res_o,
  input logic [durs_pkg::RangeW-1:0] range_one_o
);
  import durs_pkg::*;

  // A stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(range_one_o)
      && $stable(done_res_o))
    else $error("stalled result transaction changed");

  // Never trigger both sensors at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(trig_one_o && trig_two_o))
    else $error("both triggers high");

  // A trigger is only driven during a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (trig_one_o || trig_two_o) |-> busy_res_o)
    else $error("trigger high while idle");

  // Completion leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && !trig_one_o && !trig_two_o)
    else $error("done while still busy");

endmodule

bind dual_ultrasonic_ranging_sequencer durs_checker u_durs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .trig_one_o  (trig_one_o),
  .trig_two_o  (trig_two_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .range_one_o (range_one_o)
);
